FILE: src/fcca_pkg.sv
// Shared types and codes of the FAT cluster chain allocator.
// No dependencies; used by fat_cluster_chain_allocator.
package fcca_pkg;

  // Operation codes carried by func
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_TOO_LARGE  = 2'd3
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BACKED_COUNT = 2'd0;
  localparam logic [1:0] CFG_FAT16_MODE   = 2'd1;
  localparam logic [1:0] CFG_FINAL_INCOMP = 2'd2;

  // Table constants
  localparam logic [16:0] FIRST_CLUSTER = 17'd2;
  localparam logic [16:0] FAT16_CAP     = 17'h0fff0;
  localparam logic [15:0] CHAIN_END     = 16'hffff;
  localparam logic [15:0] FREE_ENTRY    = 16'h0000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_WAIT,
    S_SCAN,
    S_LINK_START,
    S_LINK_FIRST,
    S_LINK_RD,
    S_LINK_WR,
    S_RESP
  } state_e;

endpackage

FILE: src/fcca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fcca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/fat_cluster_chain_allocator.sv
// FAT cluster chain allocator. Free/write: result valid in the cycle after the transaction
// is taken; read: table read, then result. Next transaction taken in the cycle after the
// last result is accepted. Allocate: table entries scanned from cluster 2 up to the usable
// limit (or until enough free entries are found), a final check, fetch states S_LINK_START
// and S_LINK_FIRST, then per chain link S_LINK_RD, S_LINK_WR and S_RESP, plus stalls.
// Reset clears control and dirty flag; table contents stay undefined until written.
module fat_cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = 65536,
  parameter int MAX_REQUEST   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] cluster_index_i,
  input  logic [15:0] entry_value_i,
  input  logic [6:0]  request_count_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] cluster_number_o,
  output logic        cluster_valid_o,
  output logic [15:0] read_value_o,
  output logic        last_result_o,
  output logic        table_dirty_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int FW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
  localparam int CW = $clog2(MAX_REQUEST + 1);
  localparam logic [16:0] TABLE_LIMIT = 17'(TABLE_ENTRIES);
  localparam logic [6:0]  MAX_REQ     = 7'(MAX_REQUEST);

  // Configuration registers
  logic [15:0] backed_q;
  logic        fat16_q;
  logic        final_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backed_q    <= 16'd0;
      fat16_q     <= 1'b1;
      final_inc_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fcca_pkg::CFG_BACKED_COUNT: backed_q    <= cfg_wdata_i;
        fcca_pkg::CFG_FAT16_MODE:   fat16_q     <= cfg_wdata_i[0];
        fcca_pkg::CFG_FINAL_INCOMP: final_inc_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Usable scan limit
  logic [16:0] limit_raw, limit_cap, limit_cur;
  always_comb begin
    limit_raw = {1'b0, backed_q} + fcca_pkg::FIRST_CLUSTER;
    limit_cap = (fat16_q && limit_raw > fcca_pkg::FAT16_CAP) ? fcca_pkg::FAT16_CAP
                                                            : limit_raw;
    limit_cur = (limit_cap > TABLE_LIMIT) ? TABLE_LIMIT : limit_cap;
  end

  // Control state
  fcca_pkg::state_e state_q, state_d;
  logic            dirty_q, dirty_d;
  logic            out_valid_q, out_valid_d;
  logic [16:0]     scan_addr_q, scan_addr_d;
  logic [16:0]     limit_q, limit_d;
  logic            pend_q, pend_d;
  logic [15:0]     pend_addr_q, pend_addr_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   link_i_q, link_i_d;
  logic [15:0]     cur_q, cur_d;

  // Result payload
  fcca_pkg::status_e status_q, status_d;
  logic [15:0]     num_q, num_d;
  logic            cvalid_q, cvalid_d;
  logic [15:0]     rdval_q, rdval_d;
  logic            last_q, last_d;

  // Memory ports
  logic          tbl_we, tbl_re;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [15:0]   tbl_wdata, tbl_rdata;
  logic          fl_we, fl_re;
  logic [FW-1:0] fl_waddr, fl_raddr;
  logic [15:0]   fl_wdata, fl_rdata;

  fcca_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  fcca_ram #(.WIDTH(16), .DEPTH(MAX_REQUEST)) u_found (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .re_i    (fl_re),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  logic          in_fire, out_fire, idx_inside, hit, issue, link_last;
  logic [CW-1:0] n_after, link_next;

  assign in_ready_o = (state_q == fcca_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign idx_inside = ({1'b0, cluster_index_i} < TABLE_LIMIT);

  // Scan bookkeeping
  assign hit       = pend_q && (tbl_rdata == fcca_pkg::FREE_ENTRY);
  assign n_after   = n_q + CW'(hit);
  assign issue     = (scan_addr_q < limit_q) && (n_after < count_q);
  assign link_next = link_i_q + CW'(1);
  assign link_last = (link_next == n_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    dirty_d     = dirty_q;
    out_valid_d = out_valid_q;
    scan_addr_d = scan_addr_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    count_d     = count_q;
    n_d         = n_q;
    link_i_d    = link_i_q;
    cur_d       = cur_q;
    status_d    = status_q;
    num_d       = num_q;
    cvalid_d    = cvalid_q;
    rdval_d     = rdval_q;
    last_d      = last_q;
    tbl_we      = 1'b0;
    tbl_waddr   = cluster_index_i[AW-1:0];
    tbl_wdata   = entry_value_i;
    tbl_re      = 1'b0;
    tbl_raddr   = cluster_index_i[AW-1:0];
    fl_we       = 1'b0;
    fl_waddr    = n_q[FW-1:0];
    fl_wdata    = pend_addr_q;
    fl_re       = 1'b0;
    fl_raddr    = link_next[FW-1:0];

    case (state_q)
      fcca_pkg::S_IDLE: begin
        if (in_fire) begin
          // default single result
          status_d = fcca_pkg::ST_OK;
          num_d    = 16'd0;
          cvalid_d = 1'b0;
          rdval_d  = 16'd0;
          last_d   = 1'b1;
          case (fcca_pkg::func_e'(func_i))
            fcca_pkg::FUNC_ALLOC: begin
              if (request_count_i > MAX_REQ) begin
                status_d    = fcca_pkg::ST_TOO_LARGE;
                out_valid_d = 1'b1;
                state_d     = fcca_pkg::S_RESP;
              end else if (request_count_i == 7'd0) begin
                out_valid_d = 1'b1;
                state_d     = fcca_pkg::S_RESP;
              end else begin
                count_d     = request_count_i[CW-1:0];
                limit_d     = limit_cur;
                scan_addr_d = fcca_pkg::FIRST_CLUSTER;
                pend_d      = 1'b0;
                n_d         = '0;
                state_d     = fcca_pkg::S_SCAN;
              end
            end
            fcca_pkg::FUNC_FREE: begin
              if (idx_inside) begin
                tbl_we    = 1'b1;
                tbl_wdata = fcca_pkg::FREE_ENTRY;
                dirty_d   = 1'b1;
              end
              out_valid_d = 1'b1;
              state_d     = fcca_pkg::S_RESP;
            end
            fcca_pkg::FUNC_WRITE: begin
              if (idx_inside) begin
                tbl_we  = 1'b1;
                dirty_d = 1'b1;
              end
              out_valid_d = 1'b1;
              state_d     = fcca_pkg::S_RESP;
            end
            default: begin
              if (idx_inside) begin
                tbl_re  = 1'b1;
                state_d = fcca_pkg::S_READ_WAIT;
              end else begin
                out_valid_d = 1'b1;
                state_d     = fcca_pkg::S_RESP;
              end
            end
          endcase
        end
      end

      fcca_pkg::S_READ_WAIT: begin
        rdval_d     = tbl_rdata;
        out_valid_d = 1'b1;
        state_d     = fcca_pkg::S_RESP;
      end

      // One table read issued per cycle; its data is checked the next cycle
      fcca_pkg::S_SCAN: begin
        if (hit) begin
          fl_we = 1'b1;
        end
        n_d = n_after;
        if (issue) begin
          tbl_re      = 1'b1;
          tbl_raddr   = scan_addr_q[AW-1:0];
          pend_d      = 1'b1;
          pend_addr_d = scan_addr_q[15:0];
          scan_addr_d = scan_addr_q + 17'd1;
        end else begin
          pend_d = 1'b0;
          if (n_after == count_q) begin
            dirty_d  = 1'b1;
            link_i_d = '0;
            state_d  = fcca_pkg::S_LINK_START;
          end else begin
            status_d    = final_inc_q ? fcca_pkg::ST_INCOMPLETE : fcca_pkg::ST_NO_FREE;
            out_valid_d = 1'b1;
            state_d     = fcca_pkg::S_RESP;
          end
        end
      end

      fcca_pkg::S_LINK_START: begin
        fl_re    = 1'b1;
        fl_raddr = '0;
        state_d  = fcca_pkg::S_LINK_FIRST;
      end

      fcca_pkg::S_LINK_FIRST: begin
        cur_d   = fl_rdata;
        state_d = fcca_pkg::S_LINK_RD;
      end

      // Fetch the successor of the current cluster
      fcca_pkg::S_LINK_RD: begin
        fl_re   = !link_last;
        state_d = fcca_pkg::S_LINK_WR;
      end

      // Link the current cluster and emit it
      fcca_pkg::S_LINK_WR: begin
        tbl_we      = 1'b1;
        tbl_waddr   = cur_q[AW-1:0];
        tbl_wdata   = link_last ? fcca_pkg::CHAIN_END : fl_rdata;
        status_d    = fcca_pkg::ST_OK;
        num_d       = cur_q;
        cvalid_d    = 1'b1;
        rdval_d     = 16'd0;
        last_d      = link_last;
        cur_d       = fl_rdata;
        out_valid_d = 1'b1;
        state_d     = fcca_pkg::S_RESP;
      end

      fcca_pkg::S_RESP: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = fcca_pkg::S_IDLE;
          end else begin
            link_i_d = link_next;
            state_d  = fcca_pkg::S_LINK_RD;
          end
        end
      end

      default: state_d = fcca_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcca_pkg::S_IDLE;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      link_i_q    <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      link_i_q    <= link_i_d;
      count_q     <= count_d;
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    limit_q     <= limit_d;
    pend_addr_q <= pend_addr_d;
    cur_q       <= cur_d;
    status_q    <= status_d;
    num_q       <= num_d;
    cvalid_q    <= cvalid_d;
    rdval_q     <= rdval_d;
    last_q      <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign cluster_number_o = num_q;
  assign cluster_valid_o  = cvalid_q;
  assign read_value_o     = rdval_q;
  assign last_result_o    = last_q;
  assign table_dirty_o    = dirty_q;

endmodule

FILE: sim/tb_fat_cluster_chain_allocator.sv
`timescale 1ns / 100ps
// Testbench for fat_cluster_chain_allocator: directed and random FAT operations
// under random valid/ready idling, checked against a behavioral table model.
// Depends on fcca_pkg and the fat_cluster_chain_allocator RTL.
module tb_fat_cluster_chain_allocator;

  localparam int TABLE_ENTRIES = 65536;
  localparam int MAX_REQUEST   = 64;
  // clusters SCAN_START .. LOAD_TOP-1 are preloaded so scans never hit unwritten entries
  localparam int LOAD_TOP      = 68;
  localparam int unsigned SCAN_START = 32'(fcca_pkg::FIRST_CLUSTER);
  localparam int unsigned SCAN_CAP   = 32'(fcca_pkg::FAT16_CAP);

  typedef struct {
    fcca_pkg::func_e func;
    logic [15:0] idx;
    logic [15:0] value;
    logic [6:0]  count;
    bit          hold;  // wait for all results before presenting
  } fat_op_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] cluster;
    logic        cluster_vld;
    logic [15:0] rd_value;
    logic        last;
    logic        dirty;
  } fat_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_addr_i      = fcca_pkg::CFG_BACKED_COUNT;
  logic [15:0] cfg_wdata_i     = 16'h0000;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i          = fcca_pkg::FUNC_ALLOC;
  logic [15:0] cluster_index_i = 16'h0000;
  logic [15:0] entry_value_i   = 16'h0000;
  logic [6:0]  request_count_i = 7'd0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] cluster_number_o;
  logic        cluster_valid_o;
  logic [15:0] read_value_o;
  logic        last_result_o;
  logic        table_dirty_o;

  // FAT model state and shadow of the configuration registers
  logic [15:0] fat_model [0:TABLE_ENTRIES-1];
  logic        dirty_model  = 1'b0;
  logic [15:0] backed_model = 16'h0000;
  logic        fat16_model  = 1'b1;
  logic        final_model  = 1'b0;

  fat_op_t     pending_ops [$];
  fat_result_t expected_results [$];
  bit          loaded [0:TABLE_ENTRIES-1];
  int unsigned loaded_list [$];
  int          mismatches = 0;

  fat_op_t     drv_op;
  int unsigned drv_gap  = 0;
  bit          drv_calm = 1'b0;
  fat_result_t mon_exp;
  int unsigned mon_stall = 0;
  bit          mon_calm  = 1'b0;

  fat_cluster_chain_allocator #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_REQUEST  (MAX_REQUEST)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .cluster_index_i (cluster_index_i),
    .entry_value_i   (entry_value_i),
    .request_count_i (request_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .cluster_number_o(cluster_number_o),
    .cluster_valid_o (cluster_valid_o),
    .read_value_o    (read_value_o),
    .last_result_o   (last_result_o),
    .table_dirty_o   (table_dirty_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle length: mostly none, some short, a few long; none in calm stretches
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic fat_result_t mk_result(input logic [1:0] st, input logic [15:0] num,
                                            input logic vld, input logic [15:0] rd,
                                            input logic last);
    fat_result_t r;
    r.status      = st;
    r.cluster     = num;
    r.cluster_vld = vld;
    r.rd_value    = rd;
    r.last        = last;
    r.dirty       = dirty_model;
    return r;
  endfunction

  // Append one expected result
  function automatic void add_result(input fat_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Apply one operation to the FAT model and queue the results it yields
  task automatic predict_fat_op(input fat_op_t op);
    int unsigned limit;
    int unsigned c;
    int          n;
    logic [15:0] found [$];
    logic [15:0] rd;
    rd = fcca_pkg::FREE_ENTRY;
    case (op.func)
      fcca_pkg::FUNC_ALLOC: begin
        if (op.count > MAX_REQUEST) begin
          add_result(mk_result(fcca_pkg::ST_TOO_LARGE, 16'h0, 1'b0, 16'h0, 1'b1));
        end else begin
          limit = 32'(backed_model) + SCAN_START;
          if (fat16_model && limit > SCAN_CAP) limit = SCAN_CAP;
          if (limit > TABLE_ENTRIES) limit = TABLE_ENTRIES;
          for (c = SCAN_START; c < limit && found.size() < op.count; c++)
            if (fat_model[c] == fcca_pkg::FREE_ENTRY) found.insert(found.size(), c[15:0]);
          if (found.size() != op.count) begin
            // not enough free clusters: table untouched
            add_result(mk_result(final_model ? fcca_pkg::ST_INCOMPLETE : fcca_pkg::ST_NO_FREE,
                                 16'h0, 1'b0, 16'h0, 1'b1));
          end else if (op.count == 0) begin
            add_result(mk_result(fcca_pkg::ST_OK, 16'h0, 1'b0, 16'h0, 1'b1));
          end else begin
            // link in scan order, last link terminates the chain
            for (n = 0; n < found.size(); n++)
              fat_model[found[n]] = (n == found.size() - 1) ? fcca_pkg::CHAIN_END
                                                             : found[n + 1];
            dirty_model = 1'b1;
            for (n = 0; n < found.size(); n++)
              add_result(mk_result(fcca_pkg::ST_OK, found[n], 1'b1, 16'h0,
                                   n == found.size() - 1));
          end
        end
      end
      fcca_pkg::FUNC_FREE: begin
        if (op.idx < TABLE_ENTRIES) begin
          fat_model[op.idx] = fcca_pkg::FREE_ENTRY;
          dirty_model = 1'b1;
        end
        add_result(mk_result(fcca_pkg::ST_OK, 16'h0, 1'b0, rd, 1'b1));
      end
      fcca_pkg::FUNC_WRITE: begin
        if (op.idx < TABLE_ENTRIES) begin
          fat_model[op.idx] = op.value;
          dirty_model = 1'b1;
        end
        add_result(mk_result(fcca_pkg::ST_OK, 16'h0, 1'b0, rd, 1'b1));
      end
      default: begin
        if (op.idx < TABLE_ENTRIES) rd = fat_model[op.idx];
        add_result(mk_result(fcca_pkg::ST_OK, 16'h0, 1'b0, rd, 1'b1));
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Driver: presents pending transactions, predicts results on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_fat_op(drv_op);
        drv_gap = idle_len(drv_calm);
        if ($urandom_range(0, 24) == 0) drv_calm = !drv_calm;
      end
      if (!in_valid_i || in_ready_o) begin
        if (drv_gap != 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].hold && expected_results.size() != 0)) begin
          drv_op = pending_ops.pop_front();
          in_valid_i      <= 1'b1;
          func_i          <= drv_op.func;
          cluster_index_i <= drv_op.idx;
          entry_value_i   <= drv_op.value;
          request_count_i <= drv_op.count;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compares each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mon_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: actual status %h cluster %h",
                   $time, status_o, cluster_number_o);
          mismatches++;
        end else begin
          mon_exp = expected_results.pop_front();
          check_field("status", 16'(mon_exp.status), 16'(status_o));
          check_field("cluster_number", mon_exp.cluster, cluster_number_o);
          check_field("cluster_valid", 16'(mon_exp.cluster_vld), 16'(cluster_valid_o));
          check_field("read_value", mon_exp.rd_value, read_value_o);
          check_field("last_result", 16'(mon_exp.last), 16'(last_result_o));
          check_field("table_dirty", 16'(mon_exp.dirty), 16'(table_dirty_o));
        end
        if ($urandom_range(0, 24) == 0) mon_calm = !mon_calm;
      end
      if (mon_stall != 0) begin
        mon_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        mon_stall = idle_len(mon_calm);
      end
    end
  end

  task automatic queue_op(input fcca_pkg::func_e f, input int unsigned idx,
                          input int unsigned value, input int unsigned cnt, input bit hold);
    fat_op_t op;
    op.func  = f;
    op.idx   = idx[15:0];
    op.value = value[15:0];
    op.count = cnt[6:0];
    op.hold  = hold;
    if ((f == fcca_pkg::FUNC_WRITE || f == fcca_pkg::FUNC_FREE) && !loaded[op.idx]) begin
      loaded[op.idx] = 1'b1;
      loaded_list.insert(loaded_list.size(), 32'(op.idx));
    end
    pending_ops.insert(pending_ops.size(), op);
  endtask

  function automatic int unsigned pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Random operation for phases whose scan limit lies inside the preloaded region
  task automatic queue_random_op(input bit force_hold);
    int unsigned r;
    int unsigned cnt;
    bit          hold;
    r    = $urandom_range(0, 99);
    hold = force_hold || ($urandom_range(0, 19) == 0);
    if (r < 35) begin
      cnt = $urandom_range(0, 9);
      cnt = (cnt < 7) ? $urandom_range(0, 8) :
            (cnt < 9) ? $urandom_range(9, 64) : $urandom_range(65, 127);
      queue_op(fcca_pkg::FUNC_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65535),
               cnt, hold);
    end else if (r < 50) begin
      queue_op(fcca_pkg::FUNC_FREE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) :
               $urandom_range(SCAN_START, LOAD_TOP - 1),
               $urandom_range(0, 65535), $urandom_range(0, 127), hold);
    end else if (r < 75) begin
      if ($urandom_range(0, 9) < 7)
        queue_op(fcca_pkg::FUNC_WRITE, $urandom_range(SCAN_START, LOAD_TOP - 1),
                 $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535),
                 $urandom_range(0, 127), hold);
      else
        queue_op(fcca_pkg::FUNC_WRITE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 127), hold);
    end else begin
      queue_op(fcca_pkg::FUNC_READ, pick_loaded(), $urandom_range(0, 65535),
               $urandom_range(0, 127), hold);
    end
  endtask

  // Free cnt distinct preloaded clusters, then allocate cnt: the scan stops inside
  // the preloaded region however large the limit is. Followed by a little noise.
  task automatic queue_alloc_run(input int unsigned cnt);
    int unsigned pool [$];
    int unsigned j;
    int unsigned k;
    int unsigned tmp;
    for (j = SCAN_START; j < LOAD_TOP; j++) pool.insert(pool.size(), j);
    for (j = pool.size() - 1; j > 0; j--) begin
      k       = $urandom_range(0, j);
      tmp     = pool[j];
      pool[j] = pool[k];
      pool[k] = tmp;
    end
    for (j = 0; j < cnt; j++)
      queue_op(fcca_pkg::FUNC_FREE, pool[j], $urandom_range(0, 65535),
               $urandom_range(0, 127), 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65535),
             cnt, 1'b0);
    k = $urandom_range(0, 3);
    for (j = 0; j < k; j++) begin
      case ($urandom_range(0, 3))
        0: queue_op(fcca_pkg::FUNC_WRITE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                    0, 1'b0);
        1: queue_op(fcca_pkg::FUNC_READ, pick_loaded(), 0, 0, 1'b0);
        2: queue_op(fcca_pkg::FUNC_FREE, $urandom_range(0, 65535), 0, 0, 1'b0);
        default: queue_op(fcca_pkg::FUNC_ALLOC, 0, 0,
                          $urandom_range(0, 1) ? 0 : $urandom_range(65, 127), 1'b0);
      endcase
    end
  endtask

  // Sampled at the falling edge so every update of the rising edge has settled
  task automatic wait_idle();
    while (!(pending_ops.size() == 0 && !in_valid_i && expected_results.size() == 0))
      @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] addr, input int unsigned data);
    case (addr)
      fcca_pkg::CFG_BACKED_COUNT: backed_model = data[15:0];
      fcca_pkg::CFG_FAT16_MODE:   fat16_model  = data[0];
      default:                    final_model  = data[0];
    endcase
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus phases
  initial begin
    int unsigned n;
    int unsigned nz_a;
    int unsigned nz_b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: limit is 2, so allocates never scan
    queue_op(fcca_pkg::FUNC_ALLOC, 0, 0, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, 0, 0, 1, 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, 0, 0, MAX_REQUEST, 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, 0, 0, MAX_REQUEST + 1, 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, 'hffff, 'hffff, 127, 1'b0);
    queue_op(fcca_pkg::FUNC_WRITE, 0, 'hffff, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_READ, 0, 0, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_WRITE, 'hffff, 'ha5c3, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_READ, 'hffff, 0, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_WRITE, 'hffff, 'h5a3c, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_READ, 'hffff, 0, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_WRITE, 1, 'h0000, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_WRITE, 1, 'h1234, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_FREE, 1, 'hffff, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_READ, 1, 0, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_FREE, 'hfffe, 0, 0, 1'b0);
    queue_op(fcca_pkg::FUNC_READ, 'hfffe, 0, 0, 1'b0);
    wait_idle();

    // Short allocate with the final cluster marked incomplete
    cfg_write(fcca_pkg::CFG_FINAL_INCOMP, 1);
    queue_op(fcca_pkg::FUNC_ALLOC, 0, 0, 1, 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, 0, 0, 0, 1'b0);
    wait_idle();

    // Preload the scan region with all but at most two entries free, take a
    // full-size chain out of it, then random traffic with the limit at its top
    cfg_write(fcca_pkg::CFG_BACKED_COUNT, LOAD_TOP - SCAN_START);
    cfg_write(fcca_pkg::CFG_FINAL_INCOMP, 0);
    nz_a = $urandom_range(SCAN_START, LOAD_TOP - 1);
    nz_b = $urandom_range(SCAN_START, LOAD_TOP - 1);
    for (n = SCAN_START; n < LOAD_TOP; n++)
      queue_op(fcca_pkg::FUNC_WRITE, n,
               (n == nz_a || n == nz_b) ? $urandom_range(1, 65535) : 0,
               $urandom_range(0, 127), 1'b0);
    queue_op(fcca_pkg::FUNC_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65535),
             MAX_REQUEST, 1'b0);
    for (n = 0; n < 8; n++) queue_random_op(n == 0);
    wait_idle();

    // Small random limit, incomplete final cluster
    cfg_write(fcca_pkg::CFG_BACKED_COUNT, $urandom_range(1, 20));
    cfg_write(fcca_pkg::CFG_FINAL_INCOMP, 1);
    for (n = 0; n < 5; n++) queue_random_op(1'b0);
    wait_idle();

    // Backed count 65534 without the FAT16 cap: limit is the table depth
    cfg_write(fcca_pkg::CFG_BACKED_COUNT, 65534);
    cfg_write(fcca_pkg::CFG_FAT16_MODE, 0);
    cfg_write(fcca_pkg::CFG_FINAL_INCOMP, 0);
    queue_alloc_run($urandom_range(1, 3));
    queue_alloc_run($urandom_range(1, 3));
    wait_idle();

    // Same count with the FAT16 cap
    cfg_write(fcca_pkg::CFG_FAT16_MODE, 1);
    queue_alloc_run($urandom_range(1, 3));
    wait_idle();

    // Limit of one cluster
    cfg_write(fcca_pkg::CFG_BACKED_COUNT, 1);
    cfg_write(fcca_pkg::CFG_FAT16_MODE, 0);
    for (n = 0; n < 3; n++) queue_random_op(1'b0);
    wait_idle();

    // Catch any stray results
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** fat_cluster_chain_allocator: PASSED **");
    end else begin
      $display("** fat_cluster_chain_allocator: FAILED **");
    end
    $finish;
  end

  // Watchdog: ~115 transactions, each at most a full-table scan plus 64 stalled
  // results, taken a few times over
  initial begin
    #250_000_000;
    $display("** fat_cluster_chain_allocator: FAILED **");
    $finish;
  end

endmodule
